### design/ptl_pkg.sv
// ----------------------------------------------------------------------------
// Polled timer list package
// Shared field widths, result kinds, the stored entry layout and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptl_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned TagW  = 8;
  localparam int unsigned KindW = 2;

  typedef enum logic [KindW-1:0] {
    KIND_REGISTERED = 2'd0,
    KIND_REJECTED   = 2'd1,
    KIND_FIRED      = 2'd2,
    KIND_NONE       = 2'd3
  } kind_e;

  typedef enum logic {
    REQ_REGISTER = 1'b0,
    REQ_POLL     = 1'b1
  } req_e;

  typedef struct packed {
    logic [TimeW-1:0] start;
    logic [TimeW-1:0] ivl;
    logic             rep;
    logic [TagW-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic reg_item;
    logic poll_begin;
    logic walk;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic walk_done;
  } ctl_stat_t;

endpackage

### design/polled_timer_list.sv
// ----------------------------------------------------------------------------
// Polled timer list
// An ordered list of software timers, each one-shot or repeating.
// Raise start_i with the item fields while busy_o is low; the item is taken
// at that clock edge. A register item appends a timer started at now_i, or
// is rejected when the list is full. A poll item checks every timer against
// now_i, reports each one that is due (or a none result), advances repeating
// timers by one interval and removes one-shot timers, closing up the list.
// Results appear on kind_o, fired_tag_o and last_o for one cycle with
// strobe_o high; last_o marks the final result of an item. The receiver
// cannot hold results off and must take each one as it comes.
// A register item gives its result in the cycle after it is taken and the next
// item may follow immediately. A poll keeps busy_o high while it reads each
// timer once through the single read port of the entry memory; its final
// result appears as busy_o falls.
// Reset empties the list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module polled_timer_list #(
  parameter int unsigned MaxTimers = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       req_type_i,
  input  logic [ptl_pkg::TimeW-1:0]  now_i,
  input  logic [ptl_pkg::TimeW-1:0]  interval_i,
  input  logic                       repeat_mode_i,
  input  logic [ptl_pkg::TagW-1:0]   event_tag_i,
  output logic                       strobe_o,
  output logic [ptl_pkg::KindW-1:0]  kind_o,
  output logic [ptl_pkg::TagW-1:0]   fired_tag_o,
  output logic                       last_o
);
  import ptl_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  ptl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .req_type_i(req_type_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy_o)
  );

  ptl_datapath #(
    .MaxTimers(MaxTimers)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .now_i        (now_i),
    .interval_i   (interval_i),
    .repeat_mode_i(repeat_mode_i),
    .event_tag_i  (event_tag_i),
    .strobe_o     (strobe_o),
    .kind_o       (kind_o),
    .fired_tag_o  (fired_tag_o),
    .last_o       (last_o)
  );

endmodule

### design/ptl_ram.sv
// ----------------------------------------------------------------------------
// Polled timer list RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ptl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/ptl_datapath.sv
// ----------------------------------------------------------------------------
// Polled timer list datapath
// Holds the entry memory, the fill count, the walk pointers and the result
// register. A poll reads one entry per cycle and writes kept entries back
// at the compacted position, holding one fired tag back to mark the last one.
// ----------------------------------------------------------------------------
module ptl_datapath #(
  parameter int unsigned MaxTimers = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ptl_pkg::ctl_cmd_t          cmd_i,
  output ptl_pkg::ctl_stat_t         stat_o,
  input  logic [ptl_pkg::TimeW-1:0]  now_i,
  input  logic [ptl_pkg::TimeW-1:0]  interval_i,
  input  logic                       repeat_mode_i,
  input  logic [ptl_pkg::TagW-1:0]   event_tag_i,
  output logic                       strobe_o,
  output logic [ptl_pkg::KindW-1:0]  kind_o,
  output logic [ptl_pkg::TagW-1:0]   fired_tag_o,
  output logic                       last_o
);
  import ptl_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxTimers + 1);
  localparam int unsigned AddrW = (MaxTimers > 1) ? $clog2(MaxTimers) : 1;

  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic [CntW-1:0]  wr_idx_q, wr_idx_d;
  logic             ev_q, ev_d;
  logic             pend_q, pend_d;
  logic [TagW-1:0]  pend_tag_q, pend_tag_d;
  logic [TimeW-1:0] now_q, now_d;
  logic             strobe_q, strobe_d;
  kind_e            kind_q, kind_d;
  logic [TagW-1:0]  tag_q, tag_d;
  logic             last_q, last_d;

  logic             we;
  logic [AddrW-1:0] waddr;
  entry_t           wdata;
  entry_t           rdata;
  logic [TimeW:0]   due;
  logic             fire;
  entry_t           upd;

  ptl_ram #(
    .Width($bits(entry_t)),
    .Depth(MaxTimers),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_idx_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  assign due  = {1'b0, rdata.start} + {1'b0, rdata.ivl};
  assign fire = ({1'b0, now_q} >= due);

  always_comb begin
    upd = rdata;
    if (fire && rdata.rep) begin
      upd.start = due[TimeW] ? {TimeW{1'b1}} : due[TimeW-1:0];
    end
  end

  assign stat_o.walk_done = !ev_q && (rd_idx_q == count_q);

  always_comb begin
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    wr_idx_d   = wr_idx_q;
    ev_d       = ev_q;
    pend_d     = pend_q;
    pend_tag_d = pend_tag_q;
    now_d      = now_q;
    strobe_d   = 1'b0;
    kind_d     = kind_q;
    tag_d      = tag_q;
    last_d     = last_q;
    we         = 1'b0;
    waddr      = count_q[AddrW-1:0];
    wdata      = upd;

    if (cmd_i.reg_item) begin
      strobe_d = 1'b1;
      tag_d    = '0;
      last_d   = 1'b1;
      if (count_q < CntW'(MaxTimers)) begin
        we          = 1'b1;
        waddr       = count_q[AddrW-1:0];
        wdata.start = now_i;
        wdata.ivl   = interval_i;
        wdata.rep   = repeat_mode_i;
        wdata.tag   = event_tag_i;
        count_d     = count_q + CntW'(1);
        kind_d      = KIND_REGISTERED;
      end else begin
        kind_d = KIND_REJECTED;
      end
    end

    if (cmd_i.poll_begin) begin
      now_d    = now_i;
      rd_idx_d = '0;
      wr_idx_d = '0;
      ev_d     = 1'b0;
      pend_d   = 1'b0;
    end

    if (cmd_i.walk) begin
      ev_d = (rd_idx_q < count_q);
      if (rd_idx_q < count_q) begin
        rd_idx_d = rd_idx_q + CntW'(1);
      end
      if (ev_q) begin
        if (fire) begin
          if (pend_q) begin
            strobe_d = 1'b1;
            kind_d   = KIND_FIRED;
            tag_d    = pend_tag_q;
            last_d   = 1'b0;
          end
          pend_d     = 1'b1;
          pend_tag_d = rdata.tag;
        end
        if (!fire || rdata.rep) begin
          we       = 1'b1;
          waddr    = wr_idx_q[AddrW-1:0];
          wdata    = upd;
          wr_idx_d = wr_idx_q + CntW'(1);
        end
      end
    end

    if (cmd_i.finish) begin
      count_d  = wr_idx_q;
      strobe_d = 1'b1;
      last_d   = 1'b1;
      if (pend_q) begin
        kind_d = KIND_FIRED;
        tag_d  = pend_tag_q;
      end else begin
        kind_d = KIND_NONE;
        tag_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      ev_q     <= 1'b0;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      ev_q     <= ev_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_tag_q <= pend_tag_d;
    now_q      <= now_d;
    kind_q     <= kind_d;
    tag_q      <= tag_d;
    last_q     <= last_d;
  end

  assign strobe_o    = strobe_q;
  assign kind_o      = kind_q;
  assign fired_tag_o = tag_q;
  assign last_o      = last_q;

endmodule

### design/ptl_ctrl.sv
// ----------------------------------------------------------------------------
// Polled timer list controller
// Takes new items, issues a one-cycle register command or runs the poll
// walk until the datapath reports that every entry has been evaluated.
// ----------------------------------------------------------------------------
module ptl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               req_type_i,
  input  ptl_pkg::ctl_stat_t stat_i,
  output ptl_pkg::ctl_cmd_t  cmd_o,
  output logic               busy_o
);
  import ptl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_type_i == REQ_POLL) begin
            cmd_o.poll_begin = 1'b1;
            state_d          = ST_WALK;
          end else begin
            cmd_o.reg_item = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

### sim/ptl_checker.sv
// ----------------------------------------------------------------------------
// Polled timer list checker
// Watches the item and result ports of the timer list. It keeps its own copy
// of the timer entries and predicts the results of every accepted item. Each
// result strobe is compared field by field with the oldest expected result.
// It counts failures, fired timers and rejections, and results outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ptl_checker #(
  parameter int unsigned MaxTimers = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic                      req_type_i,
  input  logic [ptl_pkg::TimeW-1:0] now_i,
  input  logic [ptl_pkg::TimeW-1:0] interval_i,
  input  logic                      repeat_mode_i,
  input  logic [ptl_pkg::TagW-1:0]  event_tag_i,
  input  logic                      strobe_i,
  input  logic [ptl_pkg::KindW-1:0] kind_i,
  input  logic [ptl_pkg::TagW-1:0]  fired_tag_i,
  input  logic                      last_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        fired_count_o,
  output int                        reject_count_o
);

  typedef struct packed {
    ptl_pkg::kind_e              kind;
    logic [ptl_pkg::TagW-1:0]    tag;
    logic                        last;
  } timer_result_t;

  logic [ptl_pkg::TimeW-1:0] slot_start [MaxTimers];
  logic [ptl_pkg::TimeW-1:0] slot_ivl   [MaxTimers];
  logic                      slot_rep   [MaxTimers];
  logic [ptl_pkg::TagW-1:0]  slot_tag   [MaxTimers];
  int unsigned               slot_count;

  timer_result_t expected_results [$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic push_result(input ptl_pkg::kind_e kind, input logic [ptl_pkg::TagW-1:0] tag);
    timer_result_t res;
    res.kind = kind;
    res.tag  = tag;
    res.last = 1'b0;
    expected_results.insert(expected_results.size(), res);
  endtask

  task automatic predict_timer_item(input logic req, input logic [ptl_pkg::TimeW-1:0] now,
                                    input logic [ptl_pkg::TimeW-1:0] ivl, input logic rep,
                                    input logic [ptl_pkg::TagW-1:0] tag);
    int unsigned             wr;
    int unsigned             n_fired;
    logic [ptl_pkg::TimeW:0] due;
    bit                      keep;
    if (req == ptl_pkg::REQ_REGISTER) begin
      if (slot_count < MaxTimers) begin
        slot_start[slot_count] = now;
        slot_ivl[slot_count]   = ivl;
        slot_rep[slot_count]   = rep;
        slot_tag[slot_count]   = tag;
        slot_count++;
        push_result(ptl_pkg::KIND_REGISTERED, '0);
      end else begin
        push_result(ptl_pkg::KIND_REJECTED, '0);
      end
    end else begin
      wr = 0;
      n_fired = 0;
      for (int unsigned rd = 0; rd < slot_count; rd++) begin
        due  = {1'b0, slot_start[rd]} + {1'b0, slot_ivl[rd]};
        keep = 1'b1;
        if ({1'b0, now} >= due) begin
          if (n_fired < MaxTimers) begin
            push_result(ptl_pkg::KIND_FIRED, slot_tag[rd]);
            n_fired++;
          end
          if (slot_rep[rd]) begin
            slot_start[rd] = due[ptl_pkg::TimeW] ? '1 : due[ptl_pkg::TimeW-1:0];
          end else begin
            keep = 1'b0;
          end
        end
        if (keep) begin
          slot_start[wr] = slot_start[rd];
          slot_ivl[wr]   = slot_ivl[rd];
          slot_rep[wr]   = slot_rep[rd];
          slot_tag[wr]   = slot_tag[rd];
          wr++;
        end
      end
      slot_count = wr;
      if (n_fired == 0) begin
        push_result(ptl_pkg::KIND_NONE, '0);
      end
    end
    expected_results[expected_results.size()-1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t exp_res;
    if (!rst_ni) begin
      slot_count = 0;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (strobe_i === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result kind %0d tag %0h with no item waiting",
                                    kind_i, fired_tag_i));
        end else begin
          exp_res = expected_results.pop_front();
          if (kind_i !== exp_res.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", kind_i, exp_res.kind));
          end
          if (fired_tag_i !== exp_res.tag) begin
            report_mismatch($sformatf("fired_tag %0h, expected %0h", fired_tag_i, exp_res.tag));
          end
          if (last_i !== exp_res.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", last_i, exp_res.last));
          end
          if (exp_res.kind == ptl_pkg::KIND_FIRED) begin
            fired_count_o++;
          end
          if (exp_res.kind == ptl_pkg::KIND_REJECTED) begin
            reject_count_o++;
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        predict_timer_item(req_type_i, now_i, interval_i, repeat_mode_i, event_tag_i);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Polled timer list testbench
// Drives register and poll items into the timer list in random bursts, after
// a directed opening that covers zero intervals, timers started at time zero,
// the largest times, a full list and a poll that fires all but one timer. A
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned MaxTimers   = 16;
  localparam int unsigned RandomItems = 320;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      start_i       = 1'b0;
  logic                      req_type_i    = 1'b0;
  logic [ptl_pkg::TimeW-1:0] now_i         = '0;
  logic [ptl_pkg::TimeW-1:0] interval_i    = '0;
  logic                      repeat_mode_i = 1'b0;
  logic [ptl_pkg::TagW-1:0]  event_tag_i   = '0;
  logic                      busy_o;
  logic                      strobe_o;
  logic [ptl_pkg::KindW-1:0] kind_o;
  logic [ptl_pkg::TagW-1:0]  fired_tag_o;
  logic                      last_o;

  int fail_count;
  int pending;
  int fired_count;
  int reject_count;
  int n_register;
  int n_poll;

  logic [ptl_pkg::TimeW-1:0] wall_ms;

  polled_timer_list #(
    .MaxTimers(MaxTimers)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .now_i        (now_i),
    .interval_i   (interval_i),
    .repeat_mode_i(repeat_mode_i),
    .event_tag_i  (event_tag_i),
    .strobe_o     (strobe_o),
    .kind_o       (kind_o),
    .fired_tag_o  (fired_tag_o),
    .last_o       (last_o)
  );

  ptl_checker #(
    .MaxTimers(MaxTimers)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .req_type_i    (req_type_i),
    .now_i         (now_i),
    .interval_i    (interval_i),
    .repeat_mode_i (repeat_mode_i),
    .event_tag_i   (event_tag_i),
    .strobe_i      (strobe_o),
    .kind_i        (kind_o),
    .fired_tag_i   (fired_tag_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .fired_count_o (fired_count),
    .reject_count_o(reject_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic drive_item(input logic req, input logic [ptl_pkg::TimeW-1:0] now,
                            input logic [ptl_pkg::TimeW-1:0] ivl, input logic rep,
                            input logic [ptl_pkg::TagW-1:0] tag);
    start_i       <= 1'b1;
    req_type_i    <= req;
    now_i         <= now;
    interval_i    <= ivl;
    repeat_mode_i <= rep;
    event_tag_i   <= tag;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (req == ptl_pkg::REQ_POLL) begin
      n_poll++;
    end else begin
      n_register++;
    end
  endtask

  task automatic idle_cycles(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_random_item();
    int unsigned               pick;
    logic                      req;
    logic [ptl_pkg::TimeW-1:0] now;
    logic [ptl_pkg::TimeW-1:0] ivl;
    logic                      rep;
    logic [ptl_pkg::TagW-1:0]  tag;
    pick = $urandom_range(0, 99);
    tag  = 8'($urandom);
    if (pick < 80) begin
      if ($urandom_range(0, 49) == 0) begin
        wall_ms = $urandom;
      end else begin
        wall_ms = wall_ms + $urandom_range(0, 40);
      end
      now = wall_ms;
      req = ($urandom_range(0, 99) < 48) ? ptl_pkg::REQ_POLL : ptl_pkg::REQ_REGISTER;
      ivl = (pick < 8) ? '0 : $urandom_range(0, 80);
      rep = ($urandom_range(0, 99) < 15);
    end else begin
      now = $urandom;
      ivl = $urandom;
      req = 1'($urandom);
      rep = 1'($urandom);
    end
    drive_item(req, now, ivl, rep, tag);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    wall_ms = $urandom_range(0, 1000);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_item(ptl_pkg::REQ_REGISTER, '0, '0, 1'b0, 8'h00);
    drive_item(ptl_pkg::REQ_REGISTER, '0, 32'd5, 1'b1, 8'hFF);
    drive_item(ptl_pkg::REQ_REGISTER, '1, '1, 1'b1, 8'hA5);
    drive_item(ptl_pkg::REQ_POLL, '0, '1, 1'b1, 8'h5A);
    drive_item(ptl_pkg::REQ_POLL, 32'd10, '0, 1'b0, 8'h00);
    drive_item(ptl_pkg::REQ_POLL, '1, '0, 1'b0, 8'h00);
    drain_results();
    for (int unsigned i = 0; i < MaxTimers; i++) begin
      drive_item(ptl_pkg::REQ_REGISTER, 32'd100, i, i[0], 8'(8'hF0 + i));
    end
    drive_item(ptl_pkg::REQ_POLL, '1, '0, 1'b0, 8'h00);
    drive_item(ptl_pkg::REQ_POLL, '0, '0, 1'b0, 8'h00);
    drain_results();

    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 12);
      for (int unsigned b = 0; b < burst; b++) begin
        send_random_item();
        sent++;
        if (sent == RandomItems / 2) begin
          drain_results();
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        idle_cycles(gap);
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d register items and %0d poll items after a directed opening.",
             n_register, n_poll);
    $display("Saw %0d fired timers and %0d rejected registrations.", fired_count, reject_count);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
